// ----- design/kls_pkg.sv -----
// shared types and codes for the keyed list store
// used by kls_ctrl, kls_dpath, keyed_list_store and kls_checker
package kls_pkg;

	typedef enum logic [2:0] {
		ACT_ADD    = 3'd0,
		ACT_REMOVE = 3'd1,
		ACT_GET    = 3'd2,
		ACT_UPDATE = 3'd3,
		ACT_ITER   = 3'd4,
		ACT_CLEAR  = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_KEY   = 3'd2,
		ST_SPACE = 3'd3,
		ST_END   = 3'd4
	} status_t;

	// source of the slot ram read address
	typedef enum logic [1:0] {
		RD_HEAD   = 2'd0,
		RD_NEXT   = 2'd1,
		RD_CURSOR = 2'd2
	} rd_sel_t;

	typedef struct packed {
		logic    capture;
		logic    walk_init;
		logic    walk_step;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    rm_commit;
		logic    upd_commit;
		logic    add_commit;
		logic    clear_all;
		logic    iter_rewind;
		logic    iter_advance;
		logic    scan_init;
		logic    scan_step;
		logic    set_res;
		status_t res_status;
		logic    res_take_value;
		logic    out_load;
	} kls_cmd_t;

	typedef struct packed {
		action_t act;
		logic    head_live;
		logic    cursor_live;
		logic    key_match;
		logic    next_ok;
		logic    full;
		logic    free_hit;
	} kls_stat_t;

endpackage

// ----- design/kls_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module kls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/kls_ctrl.sv -----
// controller state machine of the keyed list store
// depends on kls_pkg; drives kls_dpath through kls_cmd_t
module kls_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  kls_pkg::kls_stat_t st,
	output kls_pkg::kls_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_CMP    = 6'b000100,
		S_FREE   = 6'b001000,
		S_ITER   = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		logic miss;
		miss    = 1'b0;
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (st.act)
					kls_pkg::ACT_ADD, kls_pkg::ACT_REMOVE,
					kls_pkg::ACT_GET, kls_pkg::ACT_UPDATE: begin
						if (!st.head_live) begin
							if (st.act == kls_pkg::ACT_ADD) begin
								miss = 1'b1;
							end else begin
								cmd.set_res    = 1'b1;
								cmd.res_status = kls_pkg::ST_EMPTY;
								state_d        = S_FINISH;
							end
						end else begin
							cmd.walk_init = 1'b1;
							cmd.rd_en     = 1'b1;
							cmd.rd_sel    = kls_pkg::RD_HEAD;
							state_d       = S_CMP;
						end
					end
					kls_pkg::ACT_ITER: begin
						if (!st.head_live) begin
							cmd.set_res    = 1'b1;
							cmd.res_status = kls_pkg::ST_EMPTY;
							state_d        = S_FINISH;
						end else if (!st.cursor_live) begin
							cmd.iter_rewind = 1'b1;
							cmd.set_res     = 1'b1;
							cmd.res_status  = kls_pkg::ST_END;
							state_d         = S_FINISH;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = kls_pkg::RD_CURSOR;
							state_d    = S_ITER;
						end
					end
					kls_pkg::ACT_CLEAR: begin
						cmd.clear_all  = 1'b1;
						cmd.set_res    = 1'b1;
						cmd.res_status = kls_pkg::ST_OK;
						state_d        = S_FINISH;
					end
					default: begin
						// undefined action: no change
						cmd.set_res    = 1'b1;
						cmd.res_status = kls_pkg::ST_OK;
						state_d        = S_FINISH;
					end
				endcase
			end
			S_CMP: begin
				if (st.key_match) begin
					cmd.set_res = 1'b1;
					state_d     = S_FINISH;
					case (st.act)
						kls_pkg::ACT_ADD: begin
							cmd.res_status = kls_pkg::ST_KEY;
						end
						kls_pkg::ACT_REMOVE: begin
							cmd.rm_commit      = 1'b1;
							cmd.res_status     = kls_pkg::ST_OK;
							cmd.res_take_value = 1'b1;
						end
						kls_pkg::ACT_GET: begin
							cmd.res_status     = kls_pkg::ST_OK;
							cmd.res_take_value = 1'b1;
						end
						kls_pkg::ACT_UPDATE: begin
							cmd.upd_commit = 1'b1;
							cmd.res_status = kls_pkg::ST_OK;
						end
						default: begin
							cmd.res_status = kls_pkg::ST_OK;
						end
					endcase
				end else begin
					cmd.walk_step = 1'b1;
					if (st.next_ok) begin
						// issue the read of the successor while it is being stepped to
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = kls_pkg::RD_NEXT;
					end else begin
						miss = 1'b1;
					end
				end
			end
			S_FREE: begin
				if (st.free_hit) begin
					cmd.add_commit = 1'b1;
					cmd.set_res    = 1'b1;
					cmd.res_status = kls_pkg::ST_OK;
					state_d        = S_FINISH;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_ITER: begin
				cmd.iter_advance   = 1'b1;
				cmd.set_res        = 1'b1;
				cmd.res_status     = kls_pkg::ST_OK;
				cmd.res_take_value = 1'b1;
				state_d            = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// key not in the list
		if (miss) begin
			if (st.act == kls_pkg::ACT_ADD) begin
				if (st.full) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = kls_pkg::ST_SPACE;
					state_d        = S_FINISH;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_FREE;
				end
			end else begin
				cmd.set_res    = 1'b1;
				cmd.res_status = kls_pkg::ST_KEY;
				state_d        = S_FINISH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/kls_dpath.sv -----
// datapath of the keyed list store: slot rams, list pointers, walk and scan
// depends on kls_pkg and kls_ram; controlled by kls_ctrl
module kls_dpath #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kls_pkg::kls_cmd_t   cmd,
	output kls_pkg::kls_stat_t  st,
	input  logic [2:0]         action,
	input  logic signed [31:0] key,
	input  logic [31:0]        value_in,
	output logic [2:0]         status,
	output logic [31:0]        value_out,
	output logic [4:0]         entry_count,
	output logic               is_empty
);

	localparam int AddrW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int IdxW   = $clog2(CAPACITY + 1);
	localparam int StoreW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
	localparam int ExtW   = IdxW + 5;
	// capacity doubles as the null link
	localparam logic [IdxW-1:0] CapIdx = IdxW'(CAPACITY);

	kls_pkg::action_t act_q;
	logic [31:0]      key_q;
	logic [StoreW-1:0] val_q;

	logic [IdxW-1:0]  head_q, cursor_q, cur_q, prev_q, steps_q, count_q;
	logic [AddrW-1:0] scan_q;
	logic [CAPACITY-1:0] used_q;

	kls_pkg::status_t res_status_q;
	logic [31:0]      res_value_q;

	logic [2:0]       status_q;
	logic [31:0]      value_out_q;
	logic [4:0]       entry_count_q;
	logic             is_empty_q;

	logic [31:0]      key_rd;
	logic [StoreW-1:0] val_rd;
	logic [IdxW-1:0]  next_rd;
	logic [IdxW-1:0]  rd_idx;
	logic [IdxW-1:0]  steps_inc;
	logic [ExtW-1:0]  count_ext;

	logic             val_we, next_we;
	logic [AddrW-1:0] val_waddr, next_waddr;
	logic [IdxW-1:0]  next_wdata;

	function automatic logic live(input logic [IdxW-1:0] s);
		return s < CapIdx;
	endfunction

	always_comb begin
		case (cmd.rd_sel)
			kls_pkg::RD_HEAD:   rd_idx = head_q;
			kls_pkg::RD_NEXT:   rd_idx = next_rd;
			kls_pkg::RD_CURSOR: rd_idx = cursor_q;
			default:            rd_idx = head_q;
		endcase
	end

	assign steps_inc  = steps_q + IdxW'(1);
	assign count_ext  = ExtW'(count_q);

	assign val_we     = cmd.add_commit | cmd.upd_commit;
	assign val_waddr  = cmd.add_commit ? scan_q : cur_q[AddrW-1:0];
	assign next_we    = cmd.add_commit | (cmd.rm_commit & live(prev_q));
	assign next_waddr = cmd.add_commit ? scan_q : prev_q[AddrW-1:0];
	assign next_wdata = cmd.add_commit ? head_q : next_rd;

	kls_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key_ram (
		.clk   (clk),
		.we    (cmd.add_commit),
		.waddr (scan_q),
		.wdata (key_q),
		.re    (cmd.rd_en),
		.raddr (rd_idx[AddrW-1:0]),
		.rdata (key_rd)
	);

	kls_ram #(.WIDTH(StoreW), .DEPTH(CAPACITY)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_q),
		.re    (cmd.rd_en),
		.raddr (rd_idx[AddrW-1:0]),
		.rdata (val_rd)
	);

	kls_ram #(.WIDTH(IdxW), .DEPTH(CAPACITY)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.re    (cmd.rd_en),
		.raddr (rd_idx[AddrW-1:0]),
		.rdata (next_rd)
	);

	assign st.act         = act_q;
	assign st.head_live   = live(head_q);
	assign st.cursor_live = live(cursor_q);
	assign st.key_match   = (key_rd == key_q);
	assign st.next_ok     = live(next_rd) && (steps_inc < CapIdx);
	assign st.full        = (count_q >= CapIdx);
	assign st.free_hit    = !used_q[scan_q];

	// list structure
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= CapIdx;
			cursor_q <= CapIdx;
			count_q  <= '0;
			used_q   <= '0;
		end else if (cmd.clear_all) begin
			head_q   <= CapIdx;
			cursor_q <= CapIdx;
			count_q  <= '0;
			used_q   <= '0;
		end else if (cmd.add_commit) begin
			used_q[scan_q] <= 1'b1;
			head_q         <= IdxW'(scan_q);
			cursor_q       <= IdxW'(scan_q);
			count_q        <= count_q + IdxW'(1);
		end else if (cmd.rm_commit) begin
			used_q[cur_q[AddrW-1:0]] <= 1'b0;
			if (!live(prev_q)) begin
				head_q   <= next_rd;
				cursor_q <= next_rd;
			end else if (cursor_q == cur_q) begin
				cursor_q <= next_rd;
			end
			if (count_q != '0) begin
				count_q <= count_q - IdxW'(1);
			end
		end else if (cmd.iter_rewind) begin
			cursor_q <= head_q;
		end else if (cmd.iter_advance) begin
			cursor_q <= next_rd;
		end
	end

	// item, walk, scan and result registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= kls_pkg::action_t'(action);
			key_q <= $unsigned(key);
			val_q <= value_in[StoreW-1:0];
		end
		if (cmd.walk_init) begin
			cur_q   <= head_q;
			prev_q  <= CapIdx;
			steps_q <= '0;
		end else if (cmd.walk_step) begin
			prev_q  <= cur_q;
			cur_q   <= next_rd;
			steps_q <= steps_inc;
		end
		if (cmd.scan_init) begin
			scan_q <= '0;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + AddrW'(1);
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_status;
			res_value_q  <= cmd.res_take_value ? 32'(val_rd) : '0;
		end
		if (cmd.out_load) begin
			status_q      <= res_status_q;
			value_out_q   <= res_value_q;
			entry_count_q <= count_ext[4:0];
			is_empty_q    <= !live(head_q);
		end
	end

	assign status      = status_q;
	assign value_out   = value_out_q;
	assign entry_count = entry_count_q;
	assign is_empty    = is_empty_q;

endmodule

// ----- design/keyed_list_store.sv -----
// channel  | handshake           | fields
// input    | in_valid / in_stall | action, key, value_in
// output   | out_valid/out_stall | status, value_out, entry_count, is_empty
//
// an item is captured in idle, decoded, then walks the list comparing keys in the compare state (remove, get,
// update, add); add then probes slots one by one in the free-slot scan state;
// iterate reads the cursor slot in the iterate state; clear, undefined actions and
// remove, get or update on an empty list go from decode straight to the finish state
// the walk follows the next-link ram, whose registered read feeds the next address
// reset empties the list at once: no clearing pass, slot rams hold no reset value
// the next item is taken while a result waits on a stalled output register, and its
// own result then holds in the last state until that register frees
//
// top level: instantiates kls_ctrl and kls_dpath, depends on kls_pkg
module keyed_list_store #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic signed [31:0] key,
	input  logic [31:0]        value_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [31:0]        value_out,
	output logic [4:0]         entry_count,
	output logic               is_empty
);

	kls_pkg::kls_cmd_t  cmd;
	kls_pkg::kls_stat_t st;

	kls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	kls_dpath #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.action      (action),
		.key         (key),
		.value_in    (value_in),
		.status      (status),
		.value_out   (value_out),
		.entry_count (entry_count),
		.is_empty    (is_empty)
	);

endmodule

// ----- design/kls_checker.sv -----
// port-level checks of keyed_list_store, attached by bind
// depends on kls_pkg
module kls_checker #(
	parameter int CAPACITY = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [31:0] value_out,
	input logic [4:0]  entry_count,
	input logic        is_empty
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(value_out)
			&& $stable(entry_count) && $stable(is_empty))
		else $error("stalled result changed");

	// one item in flight: a transfer in closes the input for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a transfer");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (entry_count == 5'd0)))
		else $error("empty flag disagrees with count");

	a_space_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == kls_pkg::ST_SPACE) |-> (entry_count == 5'(CAPACITY)))
		else $error("no space reported below capacity");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == kls_pkg::ST_EMPTY) |-> is_empty)
		else $error("list empty reported on a non-empty store");

endmodule

bind keyed_list_store kls_checker #(.CAPACITY(CAPACITY)) u_kls_checker (.*);
